// ===== design/uda_pkg.sv =====
// shared types, constants and the bcd correction step for the decimal ascii converter
package uda_pkg;

    localparam int ValueWidth  = 64;
    localparam int DigitCount  = 20;
    localparam int DigitWidth  = 4;
    localparam int BcdWidth    = DigitCount * DigitWidth;
    localparam int BitsPerStep = 4;
    localparam int StepCount   = ValueWidth / BitsPerStep;
    localparam int StepCntW    = $clog2(StepCount);
    localparam int IdxWidth    = $clog2(DigitCount);
    localparam int CharWidth   = 6;

    localparam logic [CharWidth-1:0] AsciiZero = 6'd48;

    typedef logic [DigitCount-1:0][DigitWidth-1:0] t_bcd;
    typedef logic [IdxWidth-1:0] t_idx;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic find;
        logic next;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
    } t_sts;

    // one shift-and-add-3 pass: correct digits of 5 and up, then shift in one bit
    function automatic logic [BcdWidth+ValueWidth-1:0] dabble_one(
        input logic [BcdWidth+ValueWidth-1:0] acc
    );
        logic [BcdWidth+ValueWidth-1:0] tmp;
        tmp = acc;
        for (int d = 0; d < DigitCount; d++) begin
            if (tmp[ValueWidth + d*DigitWidth +: DigitWidth] >= 4'd5) begin
                tmp[ValueWidth + d*DigitWidth +: DigitWidth] =
                    tmp[ValueWidth + d*DigitWidth +: DigitWidth] + 4'd3;
            end
        end
        return {tmp[BcdWidth+ValueWidth-2:0], 1'b0};
    endfunction

endpackage

// ===== design/uda_ctrl.sv =====
// controller state machine for the decimal ascii converter
module uda_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output uda_pkg::t_cmd o_cmd,
    input  uda_pkg::t_sts i_sts
);
    import uda_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_FIND = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [StepCntW-1:0] LastStep = StepCntW'(StepCount - 1);

    logic [1:0]          r_state, n_state;
    logic [StepCntW-1:0] r_step_cnt, n_step_cnt;

    always_comb begin
        n_state    = r_state;
        n_step_cnt = r_step_cnt;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step_cnt = '0;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                n_step_cnt = r_step_cnt + 1'b1;
                if (r_step_cnt == LastStep) begin
                    n_state = ST_FIND;
                end
            end
            ST_FIND: begin
                o_cmd.find = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_stall) begin
                    o_cmd.next = 1'b1;
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_step_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_step_cnt <= n_step_cnt;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_EMIT);

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid) |=> (r_state == ST_CONV && r_step_cnt == '0))
        else $error("accepted item did not start conversion");

    a_conv_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV && r_step_cnt != LastStep) |=> (r_state == ST_CONV))
        else $error("conversion left early");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && i_stall) |=> (r_state == ST_EMIT && $stable(i_sts.last)))
        else $error("stalled digit did not hold");

    a_run_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !i_sts.last) |=> (r_state == ST_EMIT))
        else $error("digit run ended before last digit");

endmodule

// ===== design/uda_dp.sv =====
// datapath for the decimal ascii converter: double dabble registers and digit select
module uda_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [uda_pkg::ValueWidth-1:0] i_value,
    input  uda_pkg::t_cmd                  i_cmd,
    output uda_pkg::t_sts                  o_sts,
    output logic [uda_pkg::CharWidth-1:0]  o_digit_char
);
    import uda_pkg::*;

    logic [ValueWidth-1:0] r_bin;
    t_bcd                  r_bcd;
    t_idx                  r_idx, n_lead;
    logic [BcdWidth+ValueWidth-1:0] w_acc;
    logic [DigitWidth-1:0] w_digit;

    // four dependent passes per cycle
    always_comb begin
        w_acc = {r_bcd, r_bin};
        for (int k = 0; k < BitsPerStep; k++) begin
            w_acc = dabble_one(w_acc);
        end
    end

    // highest nonzero digit, zero value falls back to the ones digit
    always_comb begin
        n_lead = '0;
        for (int d = 0; d < DigitCount; d++) begin
            if (r_bcd[d] != '0) begin
                n_lead = IdxWidth'(d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (i_cmd.step) begin
            r_bin <= w_acc[ValueWidth-1:0];
            r_bcd <= w_acc[BcdWidth+ValueWidth-1:ValueWidth];
        end
        if (i_cmd.find) begin
            r_idx <= n_lead;
        end else if (i_cmd.next && r_idx != '0) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    assign w_digit      = r_bcd[r_idx];
    assign o_digit_char = AsciiZero + CharWidth'(w_digit);
    assign o_sts.last   = (r_idx == '0);

    a_lead_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.find) |-> (w_digit <= 4'd9 && (w_digit != '0 || r_idx == '0)))
        else $error("leading digit is zero or not decimal");

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(i_cmd))
        else $error("more than one datapath command at once");

    a_idx_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.next && r_idx != '0) |=> (r_idx == $past(r_idx) - 1'b1))
        else $error("digit index did not step down");

endmodule

// ===== design/unsigned_to_decimal_ascii_unit.sv =====
// top level of the unsigned 64-bit to decimal ascii converter
// Each accepted 64-bit value is converted to decimal by shift-and-add-3, four bits per
// cycle in the conversion state; the find state then locates the leading nonzero digit,
// then one digit leaves per cycle while i_stall is low, most significant first, with
// o_last_digit on the final one (a zero value gives the single digit '0'). The block
// holds one item at a time: o_stall is high from acceptance until the last digit is
// taken, and output stalls lengthen the time that an item occupies the block.
module unsigned_to_decimal_ascii_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [uda_pkg::ValueWidth-1:0] i_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [uda_pkg::CharWidth-1:0]  o_digit_char,
    output logic                           o_last_digit
);
    import uda_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    uda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    uda_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_value),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_digit_char (o_digit_char)
    );

    assign o_last_digit = w_sts.last;

endmodule
